// ===== rtl/core/sync_frame_receiver_defines.svh =====
// Assertion macros shared by the frame receiver checkers.
// Needs signals named clk and rst_n in the scope of each use.
`ifndef SYNC_FRAME_RECEIVER_DEFINES_SVH
`define SYNC_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs through reset.
`define SFR_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sfr_pkg.sv =====
// Shared types and constants for the sync frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfr_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int POS_W   = 9;
  localparam int CFG_IDX_W = 8;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD     = 2'd2;

  // Frame positions; payload starts at POS_DATA
  localparam logic [POS_W-1:0] POS_HUNT  = 9'd0;
  localparam logic [POS_W-1:0] POS_SYNC2 = 9'd1;
  localparam logic [POS_W-1:0] POS_FUNC  = 9'd2;
  localparam logic [POS_W-1:0] POS_LEN   = 9'd3;
  localparam logic [POS_W-1:0] POS_DATA  = 9'd4;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYNC  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYNC = 8'd1;
  localparam logic [BYTE_W-1:0]    FIRST_SYNC_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0]    SECOND_SYNC_RST = 8'hAF;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } sfr_byte_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
  } sfr_sync_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] index;
  } sfr_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/sync_frame_receiver.sv =====
// Top level of the sync frame receiver: byte-serial frame parser.
// Depends on sfr_pkg, sfr_cfg_regs, sfr_in_stage and sfr_parser.
//
// Usage:
//   Feed received bytes on in_rx_byte with in_valid; a byte transfers at a
//   rising edge with in_valid high and in_stall low. A frame is first sync,
//   second sync, function code, length L, L payload bytes and an 8-bit
//   additive checksum over all earlier frame bytes.
//   Each payload byte comes out as kind payload with its index; the checksum
//   byte gives a good or bad status carrying function code and length. Sync,
//   header and hunted bytes give no result. Keep payload only after good.
//   Results transfer on the out_ channel at a rising edge with out_valid high
//   and out_stall low.
//   Path: a transferred byte is held in the input register, and its result
//   is loaded into the result register, from which it transfers.
//   Throughput: one byte per cycle while the receiver does not stall, set by
//   the input register feeding the parser and result register in one pass.
//   The cfg_ channel writes first_sync (index 0) and second_sync (index 1);
//   cfg_ready is always high, other indexes are dropped. Write only while
//   the block is idle.
//   Reset (rst_n low, synchronous) empties both registers, sets the parser
//   hunting for a first sync and restores sync values 0xAA and 0xAF.
//   When the receiver stalls, the result holds; the next byte still moves
//   into the parser only if the result register frees, otherwise in_stall
//   rises and the input byte holds in the input register.
`default_nettype none

module sync_frame_receiver (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sfr_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [sfr_pkg::KIND_W-1:0]         out_kind,
  output logic [sfr_pkg::BYTE_W-1:0]         out_data,
  output logic [sfr_pkg::BYTE_W-1:0]         out_index,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfr_pkg::BYTE_W-1:0]    cfg_data
);
  import sfr_pkg::*;

  sfr_sync_t   sync;
  sfr_byte_t   held;
  sfr_result_t result;
  logic        advance;

  // Sync byte registers
  sfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sync      (sync)
  );

  // Capture one byte per transfer; hold it while the parser is blocked
  sfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .held       (held)
  );

  // Advance framing state and load the result register in one pass
  sfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .held      (held),
    .sync      (sync),
    .advance   (advance),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .result    (result)
  );

  assign out_kind  = result.kind;
  assign out_data  = result.data;
  assign out_index = result.index;

endmodule

`default_nettype wire

// ===== rtl/core/sfr_cfg_regs.sv =====
// Sync byte configuration registers of the frame receiver.
// Depends on sfr_pkg.
`default_nettype none

module sfr_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfr_pkg::BYTE_W-1:0]    cfg_data,
  output sfr_pkg::sfr_sync_t                sync
);
  import sfr_pkg::*;

  logic [BYTE_W-1:0] first_r;
  logic [BYTE_W-1:0] second_r;

  assign cfg_ready = 1'b1;
  assign sync = '{first: first_r, second: second_r};

  // Unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= FIRST_SYNC_RST;
      second_r <= SECOND_SYNC_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FIRST_SYNC) begin
        first_r <= cfg_data;
      end else if (cfg_index == REG_SECOND_SYNC) begin
        second_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sfr_in_stage.sv =====
// Input register stage of the frame receiver.
// Depends on sfr_pkg.
`default_nettype none

module sfr_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [sfr_pkg::BYTE_W-1:0] in_rx_byte,
  input  wire logic                      advance,
  output sfr_pkg::sfr_byte_t             held
);
  import sfr_pkg::*;

  logic              valid_r;
  logic [BYTE_W-1:0] byte_r;

  // Hold the byte while the parser cannot take it
  assign in_stall = valid_r && !advance;
  assign held = '{valid: valid_r, data: byte_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sfr_parser.sv =====
// Framing state, running checksum and result register of the frame receiver.
// Depends on sfr_pkg.
`default_nettype none

module sfr_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sfr_pkg::sfr_byte_t held,
  input  wire sfr_pkg::sfr_sync_t sync,
  output logic                    advance,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output sfr_pkg::sfr_result_t    result
);
  import sfr_pkg::*;

  logic [POS_W-1:0]  pos_r,  pos_nxt;
  logic [BYTE_W-1:0] func_r, func_nxt;
  logic [BYTE_W-1:0] len_r,  len_nxt;
  logic [BYTE_W-1:0] sum_r,  sum_nxt;
  logic              out_valid_r;
  sfr_result_t       result_r, result_nxt;
  logic              has_result;
  logic              out_free;
  logic [POS_W-1:0]  check_pos;
  logic [POS_W-1:0]  data_idx;
  logic [BYTE_W-1:0] b;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = held.valid && out_free;
  assign out_valid = out_valid_r;
  assign result    = result_r;
  assign b         = held.data;
  assign check_pos = {1'b0, len_r} + POS_DATA;
  assign data_idx  = pos_r - POS_DATA;

  always_comb begin
    pos_nxt    = pos_r;
    func_nxt   = func_r;
    len_nxt    = len_r;
    sum_nxt    = sum_r;
    has_result = 1'b0;
    result_nxt = result_r;
    unique case (pos_r)
      POS_HUNT: begin
        if (b == sync.first) begin
          sum_nxt = b;
          pos_nxt = POS_SYNC2;
        end
      end
      POS_SYNC2: begin
        // Mismatch drops back to hunting without rechecking this byte
        if (b == sync.second) begin
          sum_nxt = sum_r + b;
          pos_nxt = POS_FUNC;
        end else begin
          pos_nxt = POS_HUNT;
        end
      end
      POS_FUNC: begin
        func_nxt = b;
        sum_nxt  = sum_r + b;
        pos_nxt  = POS_LEN;
      end
      POS_LEN: begin
        len_nxt = b;
        sum_nxt = sum_r + b;
        pos_nxt = POS_DATA;
      end
      default: begin
        has_result = 1'b1;
        if (pos_r < check_pos) begin
          result_nxt = '{kind: KIND_PAYLOAD, data: b, index: data_idx[BYTE_W-1:0]};
          sum_nxt    = sum_r + b;
          pos_nxt    = pos_r + 9'd1;
        end else begin
          result_nxt = '{kind: (b == sum_r) ? KIND_GOOD : KIND_BAD,
                         data: func_r, index: len_r};
          sum_nxt    = '0;
          pos_nxt    = POS_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_HUNT;
      func_r      <= '0;
      len_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        pos_r  <= pos_nxt;
        func_r <= func_nxt;
        len_r  <= len_nxt;
        sum_r  <= sum_nxt;
      end
      if (out_free) begin
        out_valid_r <= advance && has_result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      result_r <= result_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sfr_checker.sv =====
// Port-level checker for the sync frame receiver, bound to its top level.
// Depends on sfr_pkg and sync_frame_receiver_defines.svh.
`default_nettype none
`include "sync_frame_receiver_defines.svh"

module sfr_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [sfr_pkg::KIND_W-1:0]    out_kind,
  input wire logic [sfr_pkg::BYTE_W-1:0]    out_data,
  input wire logic [sfr_pkg::BYTE_W-1:0]    out_index
);
  import sfr_pkg::*;

  // A stalled result holds
  `SFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_kind) && $stable(out_data) && $stable(out_index),
    "stalled result changed")

  // Only the three defined kinds appear
  `SFR_ASSERT_NOW(a_kind_legal, out_valid,
    out_kind == KIND_PAYLOAD || out_kind == KIND_GOOD || out_kind == KIND_BAD,
    "undefined result kind")

  // A fresh result follows a byte transfer through the input and result registers
  `SFR_ASSERT_NOW(a_out_source, $rose(out_valid),
    $past(in_valid && !in_stall, 2), "result without a byte transfer")

  // Reset empties the result register
  `SFR_ASSERT_ALWAYS_NEXT(a_rst_empty, !rst_n, !out_valid,
    "result valid after reset")

endmodule

bind sync_frame_receiver sfr_checker u_sfr_checker (.*);

`default_nettype wire

// ===== sim/sfr_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the sync frame receiver bench: a byte-level frame parser that
// predicts every result, and the queue of results still due. Needs sfr_pkg.

package sfr_tb_pkg;
  import sfr_pkg::*;

  class frame_tracker;
    logic [BYTE_W-1:0] first_sync_val;
    logic [BYTE_W-1:0] second_sync_val;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] func_code;
    logic [BYTE_W-1:0] frame_len;
    logic [BYTE_W-1:0] sum8;
    sfr_result_t       results_due[$];
    int                errors;

    function new();
      first_sync_val  = FIRST_SYNC_RST;
      second_sync_val = SECOND_SYNC_RST;
      position        = POS_HUNT;
      func_code       = '0;
      frame_len       = '0;
      sum8            = '0;
      errors          = 0;
    endfunction

    // Drop writes to any index other than the two sync registers.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
      if (idx == REG_FIRST_SYNC) begin
        first_sync_val = val;
      end else if (idx == REG_SECOND_SYNC) begin
        second_sync_val = val;
      end
    endfunction

    // Advance the frame parser by one transferred byte.
    function void take_byte(logic [BYTE_W-1:0] b);
      sfr_result_t      r;
      logic [POS_W-1:0] offs;
      case (position)
        POS_HUNT: begin
          if (b == first_sync_val) begin
            sum8     = b;
            position = POS_SYNC2;
          end
        end
        POS_SYNC2: begin
          if (b == second_sync_val) begin
            sum8     = sum8 + b;
            position = POS_FUNC;
          end else begin
            position = POS_HUNT;
          end
        end
        POS_FUNC: begin
          func_code = b;
          sum8      = sum8 + b;
          position  = POS_LEN;
        end
        POS_LEN: begin
          frame_len = b;
          sum8      = sum8 + b;
          position  = POS_DATA;
        end
        default: begin
          if (position < {1'b0, frame_len} + POS_DATA) begin
            offs     = position - POS_DATA;
            r.kind   = KIND_PAYLOAD;
            r.data   = b;
            r.index  = offs[BYTE_W-1:0];
            sum8     = sum8 + b;
            position = position + 1'b1;
          end else begin
            r.kind   = (b == sum8) ? KIND_GOOD : KIND_BAD;
            r.data   = func_code;
            r.index  = frame_len;
            position = POS_HUNT;
            sum8     = '0;
          end
          results_due.push_back(r);
        end
      endcase
    endfunction

    function int outstanding();
      return results_due.size();
    endfunction

    task flag(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task match_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                      logic [BYTE_W-1:0] index);
      sfr_result_t e;
      if (results_due.size() == 0) begin
        flag($sformatf("unexpected result kind %0d data %02h index %0d", kind, data, index));
        return;
      end
      e = results_due.pop_front();
      if (kind !== e.kind)
        flag($sformatf("kind %0d, want %0d", kind, e.kind));
      if (data !== e.data)
        flag($sformatf("data %02h, want %02h (kind %0d)", data, e.data, e.kind));
      if (index !== e.index)
        flag($sformatf("index %0d, want %0d (kind %0d)", index, e.index, e.kind));
    endtask
  endclass

endpackage

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Top-level bench for sync_frame_receiver: drives bytes and sync register
// writes, checks every result against frame_tracker. Needs sfr_pkg, sfr_tb_pkg.

module tb;
  import sfr_pkg::*;
  import sfr_tb_pkg::*;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [KIND_W-1:0]    out_kind;
  logic [BYTE_W-1:0]    out_data;
  logic [BYTE_W-1:0]    out_index;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [BYTE_W-1:0]    cfg_data   = '0;

  frame_tracker tracker = new();

  int          burst_left;
  int          bytes_sent;
  logic [7:0]  cur_first;
  logic [7:0]  cur_second;
  logic [9:0]  stall_phase = '0;

  always #1 clk = ~clk;

  sync_frame_receiver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_data   (out_data),
    .out_index  (out_index),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Receiver stall pattern: cycle through four modes in turn -- no stall,
  // light random, half random, and long runs of stall (7 of 8).
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    case (stall_phase[9:8])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= (stall_phase[2:0] != 3'd0);
    endcase
  end

  // Watch all three channels. Values read here are the ones from before the
  // edge, so every transfer is seen exactly as the block sees it.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      tracker.take_byte(in_rx_byte);
    if (rst_n && out_valid && !out_stall)
      tracker.match_result(out_kind, out_data, out_index);
    if (rst_n && cfg_valid && cfg_ready)
      tracker.write_reg(cfg_index, cfg_data);
  end

  // Present one byte and hold it until it transfers. Bytes go out in bursts;
  // at the end of a burst drop valid for a random gap, then pick a new burst
  // length (now and then a long one, so stretches run without idling).
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
    end
  endtask

  // Send one complete frame under the current sync values, with random
  // payload. For a bad frame, offset the checksum by a nonzero amount.
  task automatic send_frame(input logic [7:0] func, input int len, input bit good);
    logic [7:0] sum;
    logic [7:0] pb;
    sum = cur_first + cur_second + func + len[7:0];
    send_byte(cur_first);
    send_byte(cur_second);
    send_byte(func);
    send_byte(len[7:0]);
    for (int i = 0; i < len; i++) begin
      pb  = 8'($urandom);
      sum = sum + pb;
      send_byte(pb);
    end
    pb = 8'($urandom_range(1, 255));
    send_byte(good ? sum : sum + pb);
  endtask

  // Hold a register write until it transfers. Keep valid high when another
  // write follows at once, so valid is never lowered and raised in one step.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (!more)
      cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for every due result, then let the pipeline empty of
  // bytes that give no result, allowing a margin.
  task automatic drain();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (tracker.outstanding() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  // Load both sync registers on an idle block, with a write to an unused
  // index between them that must be dropped.
  task automatic load_syncs(input logic [7:0] f, input logic [7:0] s);
    logic [CFG_IDX_W-1:0] junk;
    drain();
    junk = CFG_IDX_W'($urandom_range(2, 255));
    cfg_write(REG_FIRST_SYNC, f, 1'b1);
    cfg_write(junk, 8'($urandom), 1'b1);
    cfg_write(REG_SECOND_SYNC, s, 1'b0);
    cur_first  = f;
    cur_second = s;
  endtask

  // Random traffic: mostly well-formed frames with random content and small
  // lengths, the rest noise, broken second syncs and cut-off frames.
  task automatic random_traffic(input int target);
    int stop_at;
    int pick;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        send_frame(8'($urandom),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12),
                   $urandom_range(0, 4) != 0);
      end else if (pick < 84) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else if (pick < 92) begin
        // first sync, then a second byte that is often wrong
        send_byte(cur_first);
        send_byte($urandom_range(0, 1) ? cur_first : 8'($urandom));
      end else begin
        // header only; the following bytes become its payload and checksum
        send_byte(cur_first);
        send_byte(cur_second);
        send_byte(8'($urandom));
        send_byte(8'($urandom_range(0, 8)));
      end
    end
  endtask

  initial begin
    logic [7:0] f;
    logic [7:0] s;
    burst_left = $urandom_range(1, 8);
    bytes_sent = 0;
    cur_first  = FIRST_SYNC_RST;
    cur_second = SECOND_SYNC_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset sync values.
    // Wrong first bytes: stay hunting.
    send_byte(8'h00);
    send_byte(8'hFF);
    // Wrong second sync equal to the first sync: back to hunting, and that
    // byte must not start a frame, so the following second sync is ignored.
    send_byte(FIRST_SYNC_RST);
    send_byte(FIRST_SYNC_RST);
    send_byte(SECOND_SYNC_RST);
    // Zero length, good checksum, function code 0x00.
    send_byte(FIRST_SYNC_RST);
    send_byte(SECOND_SYNC_RST);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h59);
    // One payload byte 0xFF, function code 0xFF, bad checksum.
    send_byte(FIRST_SYNC_RST);
    send_byte(SECOND_SYNC_RST);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h00);
    // Two payload bytes 0x00 and 0xFF, good checksum.
    send_byte(FIRST_SYNC_RST);
    send_byte(SECOND_SYNC_RST);
    send_byte(8'h5A);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hB4);

    // Random phases over several sync settings, extremes among them.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin f = 8'h00; s = 8'hFF; end
        1: begin f = 8'hFF; s = 8'h00; end
        2: begin f = 8'h55; s = 8'h55; end
        5: begin f = FIRST_SYNC_RST; s = SECOND_SYNC_RST; end
        default: begin f = 8'($urandom); s = 8'($urandom); end
      endcase
      if (p == 2) begin
        // Change the second sync after the first sync byte is already in:
        // the new value applies to the very next comparison.
        drain();
        cfg_write(REG_FIRST_SYNC, f, 1'b0);
        cur_first = f;
        send_byte(f);
        drain();
        cfg_write(REG_SECOND_SYNC, s, 1'b0);
        cur_second = s;
        send_byte(s);
        send_byte(8'h3C);
        send_byte(8'h00);
        send_byte(f + s + 8'h3C);
      end else begin
        load_syncs(f, s);
      end
      // One full-length frame reaches the last payload index.
      if (p == 3)
        send_frame(8'($urandom), 255, 1'b1);
      random_traffic(80);
    end

    drain();
    if (tracker.outstanding() != 0)
      tracker.flag($sformatf("%0d results never arrived", tracker.outstanding()));
    if (tracker.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Hard limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sync_frame_receiver.f =====
+incdir+rtl/core
rtl/core/sfr_pkg.sv
rtl/core/sfr_cfg_regs.sv
rtl/core/sfr_in_stage.sv
rtl/core/sfr_parser.sv
rtl/core/sync_frame_receiver.sv
rtl/core/sfr_checker.sv
sim/sfr_tb_pkg.sv
sim/tb.sv
